[hw/rtl/wsfu_pkg.sv]
// ----------------------------------------------------------------------------
// WebSocket frame unmasker package
// Shared types, codes and constants for the frame unmasker and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfu_pkg;

  // Width of one packet byte
  localparam int unsigned BYTE_W = 8;
  // Width of a declared payload length
  localparam int unsigned LEN_W  = 16;
  // Mask key bytes, and the width of a position within the key
  localparam int unsigned KEY_BYTES = 4;
  localparam int unsigned KEY_W     = KEY_BYTES * BYTE_W;
  localparam int unsigned POS_W     = $clog2(KEY_BYTES);

  // Frame marker after reset
  localparam logic [BYTE_W-1:0] FRAME_BYTE_RESET = 8'd129;
  // Seven-bit length codes with special meaning
  localparam logic [6:0] LEN_CODE_EXT16  = 7'd126;
  localparam logic [6:0] LEN_CODE_REJECT = 7'd127;
  // Key position of the last key byte
  localparam logic [POS_W-1:0] KEY_POS_LAST = POS_W'(KEY_BYTES - 1);

  // Header and payload phases, one-hot
  typedef enum logic [7:0] {
    PH_START   = 8'b0000_0001,
    PH_LEN     = 8'b0000_0010,
    PH_EXT_HI  = 8'b0000_0100,
    PH_EXT_LO  = 8'b0000_1000,
    PH_KEY     = 8'b0001_0000,
    PH_PAYLOAD = 8'b0010_0000,
    PH_SKIP    = 8'b0100_0000,
    PH_PASS    = 8'b1000_0000
  } phase_t;

  // Packet close status
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_SHORT  = 2'd2
  } status_t;

endpackage : wsfu_pkg

`default_nettype wire

[hw/rtl/wsfu_if.sv]
// ----------------------------------------------------------------------------
// WebSocket frame unmasker channels
// Valid/ready channels for packet bytes, decoded results and the frame marker.
// ----------------------------------------------------------------------------
`default_nettype none

// Packet byte channel
interface wsfu_in_if;
  logic                           valid;
  logic                           ready;
  logic [wsfu_pkg::BYTE_W-1:0]    packet_byte;
  logic                           packet_end;

  modport source (output valid, output packet_byte, output packet_end, input ready);
  modport sink   (input valid, input packet_byte, input packet_end, output ready);
endinterface : wsfu_in_if

// Decoded result channel
interface wsfu_out_if;
  logic                           valid;
  logic                           ready;
  logic [wsfu_pkg::BYTE_W-1:0]    text_byte;
  logic                           has_byte;
  logic                           message_end;
  wsfu_pkg::status_t              status;

  modport source (output valid, output text_byte, output has_byte, output message_end,
                  output status, input ready);
  modport sink   (input valid, input text_byte, input has_byte, input message_end,
                  input status, output ready);
endinterface : wsfu_out_if

// Frame marker write channel
interface wsfu_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wsfu_pkg::BYTE_W-1:0]    frame_first_byte;

  modport source (output valid, output frame_first_byte, input ready);
  modport sink   (input valid, input frame_first_byte, output ready);
endinterface : wsfu_cfg_if

`default_nettype wire

[hw/rtl/websocket_frame_unmasker.sv]
// ----------------------------------------------------------------------------
// WebSocket frame unmasker
// Parses a WebSocket header at the start of each packet and unmasks its
// payload, or passes non-frame packets straight through.
// ----------------------------------------------------------------------------
// One packet byte is taken per beat, and the block sustains one byte per clock
// cycle while the result channel does not stall: a byte is held in the input
// register, the header state machine and the key XOR act on it there, and its
// result lands in the output register. The per-packet state (phase, length
// count, key, key position) is updated once per byte, which is what sets the
// one-byte-per-cycle figure. A result beat is produced only for an emitted
// byte or for the last byte of a packet; header bytes, key bytes, bytes beyond
// the declared length and bytes after the first zero byte make none. A packet
// whose first byte is not the frame marker is copied up to its first zero
// byte. The frame marker may be written only while no packet is in flight; it
// resets to 129.
`default_nettype none

module websocket_frame_unmasker (
  input  wire logic  clk,
  input  wire logic  rst_n,
  wsfu_in_if.sink    in_ch,
  wsfu_out_if.source out_ch,
  wsfu_cfg_if.sink   cfg_ch
);

  import wsfu_pkg::*;

  // Configuration
  logic [BYTE_W-1:0] frame_byte_r;

  // Input register
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_end_r;
  logic              s1_adv;

  // Per-packet state
  phase_t            phase_r,   phase_nxt;
  logic              masked_r,  masked_nxt;
  logic [LEN_W-1:0]  dlen_r,    dlen_nxt;
  logic [LEN_W-1:0]  left_r,    left_nxt;
  logic [KEY_W-1:0]  key_r,     key_nxt;
  logic [POS_W-1:0]  pos_r,     pos_nxt;
  logic              stopped_r, stopped_nxt;
  logic              reject_r,  reject_nxt;

  // Step results
  logic              emit;
  logic [BYTE_W-1:0] text;
  logic [BYTE_W-1:0] key_byte;
  logic [BYTE_W-1:0] unmasked;
  status_t           st;

  // Output register
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_text_r;
  logic              out_has_r;
  logic              out_end_r;
  status_t           out_status_r;

  // Marker writes are always taken
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_byte_r <= FRAME_BYTE_RESET;
    end else if (cfg_ch.valid) begin
      frame_byte_r <= cfg_ch.frame_first_byte;
    end
  end

  // Advance the input register when the output register can take a beat
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.packet_byte;
      s1_end_r  <= in_ch.packet_end;
    end
  end

  // Select the key byte for the current payload position, first key byte on top
  always_comb begin
    case (pos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      2'd3:    key_byte = key_r[7:0];
      default: key_byte = key_r[7:0];
    endcase
  end

  assign unmasked = s1_byte_r ^ key_byte;

  // Header state machine and payload unmasking
  always_comb begin
    phase_nxt   = phase_r;
    masked_nxt  = masked_r;
    dlen_nxt    = dlen_r;
    left_nxt    = left_r;
    key_nxt     = key_r;
    pos_nxt     = pos_r;
    stopped_nxt = stopped_r;
    reject_nxt  = reject_r;
    emit        = 1'b0;
    text        = '0;
    st          = ST_OK;

    case (phase_r)
      PH_START: begin
        if (s1_byte_r == frame_byte_r) begin
          phase_nxt = PH_LEN;
        end else begin
          phase_nxt = PH_PASS;
          if (s1_byte_r == '0) begin
            stopped_nxt = 1'b1;
          end else begin
            emit = 1'b1;
            text = s1_byte_r;
          end
        end
      end
      PH_LEN: begin
        masked_nxt = s1_byte_r[7];
        dlen_nxt   = {{(LEN_W-7){1'b0}}, s1_byte_r[6:0]};
        if (s1_byte_r[6:0] == LEN_CODE_REJECT) begin
          reject_nxt = 1'b1;
          phase_nxt  = PH_SKIP;
        end else if (s1_byte_r[6:0] == LEN_CODE_EXT16) begin
          phase_nxt = PH_EXT_HI;
        end else if (s1_byte_r[7]) begin
          pos_nxt   = '0;
          phase_nxt = PH_KEY;
        end else begin
          left_nxt  = dlen_nxt;
          pos_nxt   = '0;
          phase_nxt = (dlen_nxt == '0) ? PH_SKIP : PH_PAYLOAD;
        end
      end
      PH_EXT_HI: begin
        dlen_nxt  = {s1_byte_r, {(LEN_W-BYTE_W){1'b0}}};
        phase_nxt = PH_EXT_LO;
      end
      PH_EXT_LO: begin
        dlen_nxt = {dlen_r[LEN_W-1:BYTE_W], s1_byte_r};
        pos_nxt  = '0;
        if (masked_r) begin
          phase_nxt = PH_KEY;
        end else begin
          left_nxt  = dlen_nxt;
          phase_nxt = (dlen_nxt == '0) ? PH_SKIP : PH_PAYLOAD;
        end
      end
      PH_KEY: begin
        key_nxt = {key_r[KEY_W-BYTE_W-1:0], s1_byte_r};
        if (pos_r == KEY_POS_LAST) begin
          left_nxt  = dlen_r;
          pos_nxt   = '0;
          phase_nxt = (dlen_r == '0) ? PH_SKIP : PH_PAYLOAD;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      PH_PAYLOAD: begin
        pos_nxt  = pos_r + 1'b1;
        left_nxt = left_r - 1'b1;
        if (unmasked == '0) begin
          stopped_nxt = 1'b1;
        end else if (!stopped_r) begin
          emit = 1'b1;
          text = unmasked;
        end
        if (left_r == LEN_W'(1)) begin
          phase_nxt = PH_SKIP;
        end
      end
      PH_PASS: begin
        if (s1_byte_r == '0) begin
          stopped_nxt = 1'b1;
        end else if (!stopped_r) begin
          emit = 1'b1;
          text = s1_byte_r;
        end
      end
      PH_SKIP: begin
        phase_nxt = PH_SKIP;
      end
      default: begin
        phase_nxt = PH_SKIP;
      end
    endcase

    // Close the packet: report its status and drop the per-packet state
    if (s1_end_r) begin
      if (reject_nxt) begin
        st = ST_REJECT;
      end else if (phase_nxt == PH_LEN || phase_nxt == PH_EXT_HI ||
                   phase_nxt == PH_EXT_LO || phase_nxt == PH_KEY ||
                   phase_nxt == PH_PAYLOAD) begin
        st = ST_SHORT;
      end else begin
        st = ST_OK;
      end
      phase_nxt   = PH_START;
      masked_nxt  = 1'b0;
      dlen_nxt    = '0;
      left_nxt    = '0;
      key_nxt     = '0;
      pos_nxt     = '0;
      stopped_nxt = 1'b0;
      reject_nxt  = 1'b0;
    end
  end

  // Hold the packet state, advancing once per byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      masked_r  <= 1'b0;
      dlen_r    <= '0;
      left_r    <= '0;
      key_r     <= '0;
      pos_r     <= '0;
      stopped_r <= 1'b0;
      reject_r  <= 1'b0;
    end else if (s1_adv) begin
      phase_r   <= phase_nxt;
      masked_r  <= masked_nxt;
      dlen_r    <= dlen_nxt;
      left_r    <= left_nxt;
      key_r     <= key_nxt;
      pos_r     <= pos_nxt;
      stopped_r <= stopped_nxt;
      reject_r  <= reject_nxt;
    end
  end

  // Output register: load a result beat, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= emit || s1_end_r;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_text_r   <= text;
      out_has_r    <= emit;
      out_end_r    <= s1_end_r;
      out_status_r <= st;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.text_byte   = out_text_r;
  assign out_ch.has_byte    = out_has_r;
  assign out_ch.message_end = out_end_r;
  assign out_ch.status      = out_status_r;

  // A zero byte never leaves the block
  a_no_zero_byte : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_has_r |-> out_text_r != '0)
    else $error("zero byte emitted");

  // A beat carries a byte or closes a packet
  a_beat_has_reason : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_has_r || out_end_r)
    else $error("empty result beat");

  // Status is reported only on the closing beat
  a_status_at_end : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_end_r |-> out_status_r == ST_OK)
    else $error("status outside packet end");

  // A closing beat leaves the header state back at packet start
  a_restart_after_end : assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_end_r |=> phase_r == PH_START && !stopped_r && !reject_r)
    else $error("packet state not cleared");

endmodule : websocket_frame_unmasker

`default_nettype wire

[test/websocket_frame_unmasker_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame unmasker testbench
// Streams frame, pass-through, rejected, truncated and over-long packets into
// the unmasker under random source gaps and sink stalls. It changes the frame
// marker between runs and checks every result beat against a local decoder.
// ----------------------------------------------------------------------------

module websocket_frame_unmasker_tb;

  import wsfu_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 11;
  localparam int MAX_WAIT      = 11;
  localparam int SETTLE_CYCLES = 4;       // result latency plus margin
  localparam int RANDOM_ITEMS  = 1925;
  localparam int RUN_PHASES    = 6;
  localparam int END_WAIT      = 2000;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int REPORT_LIMIT  = 10;

  typedef enum logic [1:0] {EV_BYTE, EV_MARKER, EV_DRAIN} stim_kind_t;

  typedef struct {
    stim_kind_t        kind;
    logic [BYTE_W-1:0] data;
    logic              last;
  } stim_t;

  typedef struct {
    logic [BYTE_W-1:0] text;
    logic              has;
    logic              closes;
    status_t           status;
    time               stamp;
  } decoded_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  wsfu_in_if  in_ch ();
  wsfu_out_if out_ch ();
  wsfu_cfg_if cfg_ch ();

  websocket_frame_unmasker dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #HALF_PERIOD clk = ~clk;

  // Pending stimulus and expected decoded beats
  stim_t    stim_q[$];
  decoded_t decoded_q[$];

  // Local decoder state
  logic [BYTE_W-1:0] frame_marker;
  phase_t            hdr_phase;
  logic              frame_masked;
  logic [LEN_W-1:0]  decl_len;
  logic [LEN_W-1:0]  payload_left;
  logic [KEY_W-1:0]  mask_word;
  logic [POS_W-1:0]  key_pos;
  logic              copy_stopped;
  logic              len_rejected;

  // Generator state
  logic [BYTE_W-1:0] gen_marker;
  int                counted_items;

  int mismatch_count = 0;
  int send_gap       = 0;
  int recv_stall     = 0;
  int settle         = 0;
  bit send_calm      = 1'b0;
  bit recv_calm      = 1'b0;
  int cycle_count    = 0;

  // -------------------------------------------------------------------------
  // Decoder
  // -------------------------------------------------------------------------
  task automatic clear_packet();
    hdr_phase    = PH_START;
    frame_masked = 1'b0;
    decl_len     = '0;
    payload_left = '0;
    mask_word    = '0;
    key_pos      = '0;
    copy_stopped = 1'b0;
    len_rejected = 1'b0;
  endtask

  task automatic open_payload();
    payload_left = decl_len;
    key_pos      = '0;
    hdr_phase    = (decl_len == '0) ? PH_SKIP : PH_PAYLOAD;
  endtask

  // Decode one accepted byte and queue the beat it should cause, if any
  task automatic unmask_byte(input logic [BYTE_W-1:0] b, input logic last);
    decoded_t          res;
    logic [BYTE_W-1:0] plain;
    res.text   = '0;
    res.has    = 1'b0;
    res.closes = last;
    res.status = ST_OK;
    res.stamp  = $time;
    case (hdr_phase)
      PH_START: begin
        if (b == frame_marker) begin
          hdr_phase = PH_LEN;
        end else begin
          hdr_phase = PH_PASS;
          if (b == '0) begin
            copy_stopped = 1'b1;
          end else begin
            res.has  = 1'b1;
            res.text = b;
          end
        end
      end
      PH_LEN: begin
        frame_masked = b[BYTE_W-1];
        decl_len     = LEN_W'(b[6:0]);
        if (b[6:0] == LEN_CODE_REJECT) begin
          len_rejected = 1'b1;
          hdr_phase    = PH_SKIP;
        end else if (b[6:0] == LEN_CODE_EXT16) begin
          hdr_phase = PH_EXT_HI;
        end else if (frame_masked) begin
          key_pos   = '0;
          hdr_phase = PH_KEY;
        end else begin
          open_payload();
        end
      end
      PH_EXT_HI: begin
        decl_len  = {b, {BYTE_W{1'b0}}};
        hdr_phase = PH_EXT_LO;
      end
      PH_EXT_LO: begin
        decl_len = {decl_len[LEN_W-1:BYTE_W], b};
        if (frame_masked) begin
          key_pos   = '0;
          hdr_phase = PH_KEY;
        end else begin
          open_payload();
        end
      end
      PH_KEY: begin
        mask_word = {mask_word[KEY_W-BYTE_W-1:0], b};
        if (key_pos == KEY_POS_LAST) open_payload();
        else key_pos = key_pos + 1'b1;
      end
      PH_PAYLOAD: begin
        plain        = b ^ mask_word[BYTE_W*(KEY_BYTES-1-key_pos) +: BYTE_W];
        key_pos      = key_pos + 1'b1;
        payload_left = payload_left - 1'b1;
        if (plain == '0) copy_stopped = 1'b1;
        if (!copy_stopped) begin
          res.has  = 1'b1;
          res.text = plain;
        end
        if (payload_left == '0) hdr_phase = PH_SKIP;
      end
      PH_PASS: begin
        if (b == '0) copy_stopped = 1'b1;
        if (!copy_stopped) begin
          res.has  = 1'b1;
          res.text = b;
        end
      end
      default: ;
    endcase
    // Close the packet: rejection wins over a short packet
    if (last) begin
      if (len_rejected) begin
        res.status = ST_REJECT;
      end else if (hdr_phase inside {PH_LEN, PH_EXT_HI, PH_EXT_LO, PH_KEY, PH_PAYLOAD}) begin
        res.status = ST_SHORT;
      end
      clear_packet();
    end
    if (res.has || last) decoded_q.push_back(res);
  endtask

  // -------------------------------------------------------------------------
  // Stimulus builders
  // -------------------------------------------------------------------------
  task automatic add_byte(input logic [BYTE_W-1:0] b, input logic last);
    stim_t s;
    s.kind = EV_BYTE;
    s.data = b;
    s.last = last;
    stim_q.push_back(s);
  endtask

  task automatic add_control(input stim_kind_t kind, input logic [BYTE_W-1:0] value);
    stim_t s;
    s.kind = kind;
    s.data = value;
    s.last = 1'b0;
    stim_q.push_back(s);
    if (kind == EV_MARKER) gen_marker = value;
  endtask

  // Build a frame packet; keep > 0 cuts it to that many bytes
  task automatic add_frame(input bit masked, input int len, input bit ext16,
                           input int keep, input int extra, input int zero_at);
    logic [BYTE_W-1:0] pkt[$];
    logic [KEY_W-1:0]  key;
    logic [BYTE_W-1:0] plain;
    int                useful;
    int                i;
    key = $urandom();
    pkt.push_back(gen_marker);
    if (ext16) begin
      pkt.push_back({masked, LEN_CODE_EXT16});
      pkt.push_back(len[15:8]);
      pkt.push_back(len[7:0]);
    end else begin
      pkt.push_back({masked, len[6:0]});
    end
    if (ext16 || len != int'(LEN_CODE_REJECT)) begin
      if (masked) begin
        for (i = 0; i < KEY_BYTES; i++) pkt.push_back(key[KEY_W-1-BYTE_W*i -: BYTE_W]);
      end
      for (i = 0; i < len && (keep <= 0 || pkt.size() < keep); i++) begin
        plain = (i == zero_at) ? '0 : BYTE_W'($urandom_range(1, 255));
        pkt.push_back(masked ? plain ^ key[KEY_W-1-BYTE_W*(i%KEY_BYTES) -: BYTE_W] : plain);
      end
    end
    useful = pkt.size();
    for (i = 0; i < extra; i++) pkt.push_back(BYTE_W'($urandom_range(0, 255)));
    if (keep > 0) begin
      while (pkt.size() > keep) pkt.pop_back();
    end
    counted_items += (useful < pkt.size()) ? useful : pkt.size();
    for (i = 0; i < pkt.size(); i++) add_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // Non-frame packet: first byte differs from the marker
  task automatic add_passthrough(input int n, input int zero_at);
    logic [BYTE_W-1:0] b;
    int                i;
    for (i = 0; i < n; i++) begin
      if (i == zero_at) begin
        b = '0;
      end else if (i == 0) begin
        do b = BYTE_W'($urandom_range(0, 255)); while (b == gen_marker);
      end else begin
        b = BYTE_W'($urandom_range(1, 255));
      end
      if (i == 0 && b == gen_marker) b = ~b;
      add_byte(b, i == n - 1);
    end
    counted_items += n;
  endtask

  task automatic add_random_packet();
    int pick;
    int len;
    int span;
    int zero_at;
    int n;
    bit masked;
    bit ext16;
    pick   = $urandom_range(0, 99);
    masked = $urandom_range(0, 3) != 0;
    ext16  = $urandom_range(0, 9) == 0;
    if (ext16) len = ($urandom_range(0, 3) == 0) ? $urandom_range(126, 400) : $urandom_range(0, 40);
    else if ($urandom_range(0, 19) == 0) len = $urandom_range(100, 125);
    else len = $urandom_range(0, 24);
    zero_at = (len > 0 && $urandom_range(0, 19) == 0) ? $urandom_range(0, len - 1) : -1;
    if (pick < 15) begin
      n = $urandom_range(1, 16);
      add_passthrough(n, ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : -1);
    end else if (pick < 22) begin
      add_frame(masked, int'(LEN_CODE_REJECT), 1'b0, -1, $urandom_range(0, 6), -1);
    end else if (pick < 32) begin
      // Cut short, now and then with a declared length near the top
      if (ext16 && $urandom_range(0, 2) == 0) len = $urandom_range(401, 65535);
      span = 2 + (ext16 ? 2 : 0) + (masked ? KEY_BYTES : 0) + len;
      add_frame(masked, len, ext16, $urandom_range(1, (span - 1 < 40) ? span - 1 : 40), 0,
                zero_at);
    end else if (pick < 40) begin
      add_frame(masked, len, ext16, -1, $urandom_range(1, 5), zero_at);
    end else begin
      add_frame(masked, len, ext16, -1, 0, zero_at);
    end
  endtask

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  // -------------------------------------------------------------------------
  // Driver: byte beats and marker writes from the stimulus queue
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : byte_driver
    logic              in_v;
    logic [BYTE_W-1:0] in_b;
    logic              in_e;
    logic              cf_v;
    logic [BYTE_W-1:0] cf_d;
    if (!rst_n) begin
      in_ch.valid             <= 1'b0;
      in_ch.packet_byte       <= '0;
      in_ch.packet_end        <= 1'b0;
      cfg_ch.valid            <= 1'b0;
      cfg_ch.frame_first_byte <= '0;
      frame_marker = FRAME_BYTE_RESET;
      clear_packet();
      send_gap = 0;
      settle   = 0;
    end else begin
      in_v = in_ch.valid;
      in_b = in_ch.packet_byte;
      in_e = in_ch.packet_end;
      cf_v = cfg_ch.valid;
      cf_d = cfg_ch.frame_first_byte;
      // Decode accepted beats
      if (in_ch.valid && in_ch.ready) begin
        unmask_byte(in_ch.packet_byte, in_ch.packet_end);
        in_v = 1'b0;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        frame_marker = cfg_ch.frame_first_byte;
        cf_v = 1'b0;
      end
      // Count quiet cycles with nothing outstanding
      if (decoded_q.size() == 0 && !in_ch.valid) settle = settle + 1;
      else settle = 0;
      // Advance to the next pending item
      if (!in_v && !cf_v && stim_q.size() != 0) begin
        if (send_gap != 0) begin
          send_gap = send_gap - 1;
        end else begin
          case (stim_q[0].kind)
            EV_BYTE: begin
              in_v = 1'b1;
              in_b = stim_q[0].data;
              in_e = stim_q[0].last;
              void'(stim_q.pop_front());
              if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
              send_gap = draw_wait(send_calm);
            end
            EV_MARKER: begin
              if (settle >= SETTLE_CYCLES) begin
                cf_v = 1'b1;
                cf_d = stim_q[0].data;
                void'(stim_q.pop_front());
              end
            end
            default: begin
              if (settle >= SETTLE_CYCLES) void'(stim_q.pop_front());
            end
          endcase
        end
      end
      in_ch.valid             <= in_v;
      in_ch.packet_byte       <= in_b;
      in_ch.packet_end        <= in_e;
      cfg_ch.valid            <= cf_v;
      cfg_ch.frame_first_byte <= cf_d;
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: stall the result channel and check each beat
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    decoded_t got;
    decoded_t want;
    logic     rdy;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.text   = out_ch.text_byte;
        got.has    = out_ch.has_byte;
        got.closes = out_ch.message_end;
        got.status = out_ch.status;
        // Beats queued in this same step cannot have been produced yet
        if (decoded_q.size() == 0 || decoded_q[0].stamp == $time) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display("%0t: unexpected beat text %02h has %0d end %0d status %0d",
                     $time, got.text, got.has, got.closes, got.status);
          end
          mismatch_count++;
        end else begin
          want = decoded_q.pop_front();
          if (got.text !== want.text || got.has !== want.has ||
              got.closes !== want.closes || got.status !== want.status) begin
            if (mismatch_count < REPORT_LIMIT) begin
              $display("%0t: expected text %02h has %0d end %0d status %0d, got %02h %0d %0d %0d",
                       $time, want.text, want.has, want.closes, want.status,
                       got.text, got.has, got.closes, got.status);
            end
            mismatch_count++;
          end
        end
        if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
        recv_stall = draw_wait(recv_calm);
      end
      if (recv_stall != 0) begin
        rdy = 1'b0;
        recv_stall = recv_stall - 1;
      end else begin
        rdy = 1'b1;
      end
      out_ch.ready <= rdy;
    end
  end

  // Hard stop on a hung run
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus and end of run
  // -------------------------------------------------------------------------
  initial begin : stimulus
    int p;
    int w;
    in_ch.valid             = 1'b0;
    in_ch.packet_byte       = '0;
    in_ch.packet_end        = 1'b0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.frame_first_byte = '0;
    out_ch.ready            = 1'b0;
    gen_marker    = FRAME_BYTE_RESET;
    counted_items = 0;

    // One-byte frame packet ends inside the header
    add_byte(gen_marker, 1'b1);
    // Zero declared length
    add_byte(gen_marker, 1'b0);
    add_byte(8'h00, 1'b1);
    // Length 127: trailing bytes are dropped
    add_byte(gen_marker, 1'b0);
    add_byte({1'b1, LEN_CODE_REJECT}, 1'b0);
    add_byte(8'h55, 1'b1);
    // Pass-through halted by a zero byte
    add_byte(8'h41, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h42, 1'b1);
    // Pass-through that opens with a zero byte
    add_byte(8'h00, 1'b1);
    // Masked, two bytes; the second decodes to zero, then one byte past the length
    add_byte(gen_marker, 1'b0);
    add_byte(8'h82, 1'b0);
    add_byte(8'hA5, 1'b0);
    add_byte(8'h5A, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h01, 1'b0);
    add_byte(8'h24, 1'b0);
    add_byte(8'h5A, 1'b0);
    add_byte(8'hFF, 1'b1);
    // 16-bit length of 65535, packet ends after one payload byte
    add_byte(gen_marker, 1'b0);
    add_byte({1'b0, LEN_CODE_EXT16}, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_control(EV_DRAIN, '0);

    // Random runs; each after the first opens with a frame marker write
    for (p = 0; p < RUN_PHASES; p++) begin
      case (p)
        0: ;
        1: add_control(EV_MARKER, 8'h00);
        2: add_control(EV_MARKER, 8'hFF);
        RUN_PHASES - 1: add_control(EV_MARKER, FRAME_BYTE_RESET);
        default: add_control(EV_MARKER, BYTE_W'($urandom_range(0, 255)));
      endcase
      while (counted_items < (p + 1) * RANDOM_ITEMS / RUN_PHASES) begin
        add_random_packet();
        // Let the block run dry mid-run now and then
        if ($urandom_range(0, 99) == 0) add_control(EV_DRAIN, '0);
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the last beat to go, then for the last result
    while (stim_q.size() != 0 || in_ch.valid || cfg_ch.valid) @(negedge clk);
    for (w = 0; w < END_WAIT && decoded_q.size() != 0; w++) @(negedge clk);
    repeat (SETTLE_CYCLES * 2) @(negedge clk);
    if (decoded_q.size() != 0) begin
      if (mismatch_count < REPORT_LIMIT) begin
        $display("%0d expected beats never arrived", decoded_q.size());
      end
      mismatch_count += decoded_q.size();
    end

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule : websocket_frame_unmasker_tb
